// ===== design/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants of the sorted list insert core
// sizes of the list, command and status codes, queue item layout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

    // list size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // command kinds after decoding
    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_DUMP   = 1'b1
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_ENTRY    = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // one queued command between front and back
    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  value;
    } t_cmd;

    // queue handshake toward the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

endpackage

`default_nettype wire

// ===== design/sli_front.sv =====
// ----------------------------------------------------------------------------
// sli_front: command intake
// accepts stream transactions, decodes the command and keeps a two-deep queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sli_front
    import sli_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [DATA_W-1:0]  i_s_tdata,   // [31:0] value
    input  wire logic [0:0]         i_s_tuser,   // [0] command
    output t_cmd_q                  o_q,
    input  wire logic               i_pop
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_push;
    t_cmd       w_cmd;

    // decode incoming transaction
    assign w_cmd.op    = i_s_tuser[0] ? OP_DUMP : OP_INSERT;
    assign w_cmd.value = i_s_tdata;

    assign o_s_tready = (r_count != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;

    assign o_q.valid = (r_count != 2'd0);
    assign o_q.cmd   = r_slot[r_rd_ptr];

    // occupancy update
    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== design/sli_back.sv =====
// ----------------------------------------------------------------------------
// sli_back: list execution
// row of compare-and-shift cells for inserts, dump sequencer, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sli_back
    import sli_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd_q             i_q,
    output logic                    o_pop,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [DATA_W-1:0]       o_m_tdata,   // [31:0] data
    output logic [1:0]              o_m_tuser,   // [1:0] status
    output logic                    o_m_tlast
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic [DATA_W-1:0]  r_ent [CAPACITY];
    logic [DATA_W-1:0]  n_ent [CAPACITY];
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_out_data, n_out_data;
    t_status            r_out_status, n_out_status;
    logic               r_out_last, n_out_last;
    logic [CAPACITY-1:0] w_lt;
    logic               w_out_free;
    logic               w_full;
    logic               w_ent_we;
    logic               w_dump_last;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_full      = (r_fill == CNT_W'(CAPACITY));
    assign o_pop       = i_q.valid && (r_state == S_IDLE) && w_out_free;
    assign w_ent_we    = o_pop && (i_q.cmd.op == OP_INSERT) && !w_full;
    assign w_dump_last = ((CNT_W'(r_ptr) + CNT_W'(1)) == r_fill);

    // each cell compares its value with the new one and keeps, takes or shifts
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_lt[i] = (CNT_W'(i) < r_fill) &&
                      ($signed(r_ent[i]) < $signed(i_q.cmd.value));
        end
        n_ent[0] = w_lt[0] ? r_ent[0] : i_q.cmd.value;
        for (int i = 1; i < CAPACITY; i++) begin
            n_ent[i] = w_lt[i]   ? r_ent[i] :
                       w_lt[i-1] ? i_q.cmd.value : r_ent[i-1];
        end
    end

    // command sequencing and result formation
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_ptr        = r_ptr;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    if (i_q.cmd.op == OP_INSERT) begin
                        n_out_valid  = 1'b1;
                        n_out_data   = '0;
                        n_out_last   = 1'b1;
                        if (w_full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            n_out_status = ST_INSERTED;
                            n_fill       = r_fill + CNT_W'(1);
                        end
                    end else if (r_fill == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_data   = '0;
                        n_out_status = ST_EMPTY;
                        n_out_last   = 1'b1;
                    end else begin
                        n_state = S_DUMP;
                        n_ptr   = '0;
                    end
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_ent[r_ptr];
                    n_out_status = ST_ENTRY;
                    n_out_last   = w_dump_last;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr = r_ptr + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        if (w_ent_we) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_ent[i] <= n_ent[i];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

    // fill count stays within the list size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // dump pointer only walks over stored entries
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (CNT_W'(r_ptr) < r_fill))
        else $error("dump pointer beyond fill count");

    // a successful insert grows the list by one
    a_fill_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ent_we |=> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("insert did not grow the list");

    // the list is left alone during a dump
    a_dump_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> (r_fill == $past(r_fill)))
        else $error("fill count changed during dump");

endmodule

`default_nettype wire

// ===== design/sorted_list_insert_core.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_core: ascending sorted list of signed 32-bit values
// insert places a value in order, dump streams the list with tlast on the end
// ----------------------------------------------------------------------------
// path: an insert status passes the queue slot and then the output register;
//   the first dump entry the queue slot, the dump state and the output register
// throughput: one insert per cycle through the compare-and-shift cell row
//   while the output is free; the back end takes no new command during a dump
// reset: fill count, queue and output valid cleared; cells and output data are not
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_core
    import sli_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [DATA_W-1:0]  i_s_tdata,   // [31:0] value
    input  wire logic [0:0]         i_s_tuser,   // [0] command
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [DATA_W-1:0]       o_m_tdata,   // [31:0] data
    output logic [1:0]              o_m_tuser,   // [1:0] status
    output logic                    o_m_tlast
);

    t_cmd_q w_q;
    logic   w_pop;

    // command intake and queue
    sli_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q        (w_q),
        .i_pop      (w_pop)
    );

    // list cells and result stream
    sli_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (w_q),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ===== dv/sorted_list_insert_core_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_core_tb: self-checking bench for the sorted list core
// drives insert and dump commands over the input stream, predicts the status
// and dump results with its own copy of the list, and checks each output
// transaction in order while both sides idle and stall at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_insert_core_tb
    import sli_pkg::*;
();

    localparam int RANDOM_ITEMS = 460;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;

    // one expected output transaction
    typedef struct {
        logic [DATA_W-1:0] data;
        t_status           status;
        logic              last;
    } t_list_result;

    // mirror of the list contents and the queue of results still owed
    class sorted_list_tracker;
        logic signed [DATA_W-1:0] stored[CAPACITY];
        int                       stored_count;
        t_list_result             owed_results[$];
        int                       mismatch_count;

        function new();
            stored_count   = 0;
            mismatch_count = 0;
        endfunction

        function void owe(logic [DATA_W-1:0] data, t_status status, logic last);
            t_list_result r;
            r.data   = data;
            r.status = status;
            r.last   = last;
            owed_results.push_back(r);
        endfunction

        // work out the results of one accepted command
        function void note_command(t_op op, logic [DATA_W-1:0] value);
            int slot;
            if (op == OP_INSERT) begin
                if (stored_count >= CAPACITY) begin
                    owe('0, ST_FULL, 1'b1);
                    return;
                end
                // new value goes in front of the first entry not below it
                slot = 0;
                while (slot < stored_count && stored[slot] < $signed(value))
                    slot++;
                for (int i = stored_count; i > slot; i--)
                    stored[i] = stored[i-1];
                stored[slot] = $signed(value);
                stored_count++;
                owe('0, ST_INSERTED, 1'b1);
            end else if (stored_count == 0) begin
                owe('0, ST_EMPTY, 1'b1);
            end else begin
                for (int i = 0; i < stored_count; i++)
                    owe(stored[i], ST_ENTRY, i == stored_count - 1);
            end
        endfunction

        function void report(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (got !== want) begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            end
        endfunction

        // compare one output transaction with the oldest owed result
        function void check_result(logic [DATA_W-1:0] data, logic [1:0] status, logic last);
            t_list_result r;
            if (owed_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none actual data %h status %h last %b",
                         $time, data, status, last);
                return;
            end
            r = owed_results.pop_front();
            report("data", r.data, data);
            report("status", DATA_W'(r.status), DATA_W'(status));
            report("last", DATA_W'(r.last), DATA_W'(last));
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic [0:0]        s_tuser   = '0;
    logic              m_tready  = 1'b0;
    wire               s_tready;
    wire               m_tvalid;
    wire  [DATA_W-1:0] m_tdata;
    wire  [1:0]        m_tuser;
    wire               m_tlast;

    sorted_list_tracker tracker = new();
    int                 cycle_count = 0;
    logic               send_idles  = 1'b1;

    sorted_list_insert_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [31:0] value
        .i_s_tuser  (s_tuser),   // [0] command
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [31:0] data
        .o_m_tuser  (m_tuser),   // [1:0] status
        .o_m_tlast  (m_tlast)
    );

    // 100 MHz clock
    always #5 i_clk = ~i_clk;

    // run length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // values biased toward the extremes and the sign boundary
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // present one command and hold it until the transaction completes
    task automatic send_command(t_op op, logic [DATA_W-1:0] value);
        int gap;
        gap = send_idles ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        tracker.note_command(op, value);
    endtask

    // output side: random stalls, stretches without stalls
    initial begin : result_sink
        int stall;
        int taken;
        logic stall_on;
        taken    = 0;
        stall_on = 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 40 == 0)
                stall_on = $urandom_range(0, 2) != 0;
            stall = stall_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
            tracker.check_result(m_tdata, m_tuser, m_tlast);
            taken++;
        end
    end

    // stimulus
    initial begin : command_source
        t_op op;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty dump, extremes, equal values at both ends
        send_command(OP_DUMP, '1);
        send_command(OP_INSERT, '0);
        send_command(OP_INSERT, VAL_MAX);
        send_command(OP_INSERT, VAL_MIN);
        send_command(OP_INSERT, '0);
        send_command(OP_INSERT, '1);
        send_command(OP_INSERT, 32'd1);
        send_command(OP_DUMP, '0);
        send_command(OP_INSERT, VAL_MAX);
        send_command(OP_INSERT, VAL_MIN);
        send_command(OP_DUMP, 32'h5555_aaaa);

        // fill the rest with mixed values, dumping along the way
        while (tracker.stored_count < CAPACITY) begin
            if ($urandom_range(0, 3) == 0)
                send_command(OP_DUMP, $urandom);
            else if ($urandom_range(0, 3) == 0 && tracker.stored_count > 0)
                send_command(OP_INSERT,
                             tracker.stored[$urandom_range(0, tracker.stored_count - 1)]);
            else
                send_command(OP_INSERT, pick_value());
        end

        // full list: dropped insert, full dump
        send_command(OP_INSERT, VAL_MIN);
        send_command(OP_DUMP, '0);

        // random mix of dropped inserts and dumps of the full list
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 24 == 0)
                send_idles <= $urandom_range(0, 2) != 0;
            op = ($urandom_range(0, 2) == 0) ? OP_DUMP : OP_INSERT;
            send_command(op, pick_value());
        end
        s_tvalid <= 1'b0;

        // drain and settle
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
